/* rtl/bodd_pkg.sv */
// ============================================================================
// bodd_pkg: shared types and constants for the brake onset block
// Request layouts, controller/datapath links, register indexes and sizes.
// ============================================================================
package bodd_pkg;

    localparam int RUN_LENGTH  = 300;
    localparam int MAX_SAMPLES = 65536;

    localparam int IDX_W  = 17;             // holds MAX_SAMPLES itself
    localparam int RUN_W  = 9;              // holds RUN_LENGTH up to 511
    localparam int SUM_W  = 32;
    localparam int DATA_W = 16;
    localparam int DIST_W = 48;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    localparam logic [IDX_W-1:0] MAX_SAMPLES_C = IDX_W'(MAX_SAMPLES);
    localparam logic [RUN_W-1:0] RUN_LENGTH_C  = RUN_W'(RUN_LENGTH);

    // configuration register indexes
    localparam logic CFG_FORCE_THRESHOLD = 1'b0;
    localparam logic CFG_STEP_TIME       = 1'b1;

    localparam logic [DATA_W-1:0] STEP_TIME_RESET = 16'd655;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NEAR_END = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel;
        logic signed [DATA_W-1:0] velocity;
        logic        [DATA_W-1:0] pedal_force;
        logic                     last;
    } sample_t;

    typedef struct packed {
        logic        [1:0]        status;
        logic signed [DATA_W-1:0] start_velocity;
        logic signed [DATA_W-1:0] mean_decel;
        logic signed [DIST_W-1:0] brake_distance;
        logic                     onset_found;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic accept;       // take the sample request
        logic div_step;     // one quotient bit, refresh distance product
        logic out_load;     // move finished result into the output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } dp_sts_t;

endpackage

/* rtl/bodd_ctrl.sv */
// ============================================================================
// bodd_ctrl: sequencer for the brake onset block
// Accepts samples, runs the divider after a last sample, hands off the result.
// ============================================================================
module bodd_ctrl
    import bodd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    input  logic    sample_last,
    output logic    sample_stall,
    input  logic    result_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              can_load;

    assign sample_stall = (state_reg != S_IDLE);
    assign can_load     = !sts.out_full || !result_stall;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = sample_valid;
                if (sample_valid && sample_last)
                begin
                    state_next = S_DIV;
                    step_next  = '0;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // hold until the output register frees up
                if (can_load)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* rtl/bodd_dp.sv */
// ============================================================================
// bodd_dp: datapath for the brake onset block
// Run tracking and sums per sample, restoring divider, distance multiplier.
// ============================================================================
module bodd_dp
    import bodd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    input  sample_t           sample,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result
);

    // configuration
    logic [DATA_W-1:0] force_threshold_reg;
    logic [DATA_W-1:0] step_time_reg;

    // record state
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [RUN_W-1:0]         run_reg, run_next;
    logic                     committed_reg, committed_next;
    logic signed [SUM_W-1:0]  vsum_reg, vsum_next;
    logic signed [SUM_W-1:0]  asum_reg, asum_next;
    logic [IDX_W-1:0]         cnt_reg, cnt_next;
    logic signed [DATA_W-1:0] vbr_reg, vbr_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic [IDX_W-1:0]         last_above_reg, last_above_next;
    logic                     above_seen_reg, above_seen_next;
    logic                     ovf_reg, ovf_next;

    // end-of-record snapshot and divider
    logic [1:0]               status_reg, status_next;
    logic signed [DATA_W-1:0] sv_reg, sv_next;
    logic                     found_reg, found_next;
    logic                     neg_reg;
    logic signed [SUM_W-1:0]  vsnap_reg;
    logic [SUM_W-1:0]         quo_reg;
    logic [IDX_W-1:0]         rem_reg;
    logic [IDX_W-1:0]         dvs_reg;
    logic signed [DIST_W-1:0] dist_reg;

    logic                     out_full_reg;
    result_t                  result_reg;

    logic                     above;
    logic                     near_end;
    logic signed [SUM_W-1:0]  acc_ext, vel_ext;
    logic [IDX_W:0]           rem_shift, trial;
    logic signed [DIST_W:0]   product;
    logic [DATA_W-1:0]        q16;
    logic                     last_fire;

    assign acc_ext   = SUM_W'(sample.accel);
    assign vel_ext   = SUM_W'(sample.velocity);
    assign above     = sample.pedal_force > force_threshold_reg;
    assign last_fire = cmd.accept && sample.last;

    // per-sample record update
    always_comb
    begin
        idx_next        = idx_reg;
        run_next        = run_reg;
        committed_next  = committed_reg;
        vsum_next       = vsum_reg;
        asum_next       = asum_reg;
        cnt_next        = cnt_reg;
        vbr_next        = vbr_reg;
        prev_next       = prev_reg;
        last_above_next = last_above_reg;
        above_seen_next = above_seen_reg;
        ovf_next        = ovf_reg;
        if (!ovf_reg)
        begin
            if (idx_reg >= MAX_SAMPLES_C)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                if (!committed_reg)
                begin
                    if (above)
                    begin
                        // a new run restarts the sums
                        if (run_reg == '0)
                        begin
                            vbr_next  = (idx_reg != '0) ? prev_reg : '0;
                            vsum_next = vel_ext;
                            asum_next = acc_ext;
                            cnt_next  = IDX_W'(1);
                        end
                        else
                        begin
                            vsum_next = vsum_reg + vel_ext;
                            asum_next = asum_reg + acc_ext;
                            cnt_next  = cnt_reg + 1'b1;
                        end
                        if (run_reg < RUN_LENGTH_C)
                            run_next = run_reg + 1'b1;
                        if (run_reg >= RUN_LENGTH_C - 1'b1)
                            committed_next = 1'b1;
                        above_seen_next = 1'b1;
                        last_above_next = idx_reg;
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                else
                begin
                    vsum_next = vsum_reg + vel_ext;
                    asum_next = asum_reg + acc_ext;
                    cnt_next  = cnt_reg + 1'b1;
                end
                prev_next = sample.velocity;
                idx_next  = idx_reg + 1'b1;
            end
        end
    end

    assign near_end = ({1'b0, last_above_next} + (IDX_W+1)'(RUN_LENGTH))
                      > {1'b0, idx_next};

    always_comb
    begin
        status_next = ST_OK;
        sv_next     = '0;
        found_next  = 1'b0;
        if (ovf_next)
        begin
            status_next = ST_OVERFLOW;
        end
        else if (committed_next)
        begin
            found_next = 1'b1;
            sv_next    = vbr_next;
        end
        else if (above_seen_next && near_end)
        begin
            status_next = ST_NEAR_END;
        end
        else
        begin
            sv_next = prev_next;
        end
    end

    // restoring divide step on magnitudes
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign trial     = rem_shift - {1'b0, dvs_reg};
    assign product   = $signed({1'b0, step_time_reg}) * vsnap_reg;
    assign q16       = neg_reg ? (DATA_W'(0) - quo_reg[DATA_W-1:0]) : quo_reg[DATA_W-1:0];

    assign sts.out_full = out_full_reg;
    assign result_valid = out_full_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_threshold_reg <= '0;
            step_time_reg       <= STEP_TIME_RESET;
            idx_reg             <= '0;
            run_reg             <= '0;
            committed_reg       <= 1'b0;
            vsum_reg            <= '0;
            asum_reg            <= '0;
            cnt_reg             <= '0;
            vbr_reg             <= '0;
            prev_reg            <= '0;
            last_above_reg      <= '0;
            above_seen_reg      <= 1'b0;
            ovf_reg             <= 1'b0;
            out_full_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FORCE_THRESHOLD)
                    force_threshold_reg <= cfg_data;
                else
                    step_time_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                if (sample.last)
                begin
                    // drop the record once the snapshot is taken
                    idx_reg        <= '0;
                    run_reg        <= '0;
                    committed_reg  <= 1'b0;
                    vsum_reg       <= '0;
                    asum_reg       <= '0;
                    cnt_reg        <= '0;
                    vbr_reg        <= '0;
                    prev_reg       <= '0;
                    last_above_reg <= '0;
                    above_seen_reg <= 1'b0;
                    ovf_reg        <= 1'b0;
                end
                else
                begin
                    idx_reg        <= idx_next;
                    run_reg        <= run_next;
                    committed_reg  <= committed_next;
                    vsum_reg       <= vsum_next;
                    asum_reg       <= asum_next;
                    cnt_reg        <= cnt_next;
                    vbr_reg        <= vbr_next;
                    prev_reg       <= prev_next;
                    last_above_reg <= last_above_next;
                    above_seen_reg <= above_seen_next;
                    ovf_reg        <= ovf_next;
                end
            end
            if (cmd.out_load)
                out_full_reg <= 1'b1;
            else if (!result_stall)
                out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_fire)
        begin
            status_reg <= status_next;
            sv_reg     <= sv_next;
            found_reg  <= found_next;
            neg_reg    <= asum_next[SUM_W-1];
            quo_reg    <= asum_next[SUM_W-1] ? (SUM_W'(0) - asum_next) : asum_next;
            rem_reg    <= '0;
            dvs_reg    <= cnt_next;
            vsnap_reg  <= vsum_next;
        end
        else if (cmd.div_step)
        begin
            if (!trial[IDX_W])
            begin
                rem_reg <= trial[IDX_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[IDX_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
            dist_reg <= product[DIST_W-1:0];
        end
        if (cmd.out_load)
        begin
            result_reg.status         <= status_reg;
            result_reg.start_velocity <= sv_reg;
            result_reg.mean_decel     <= found_reg ? q16 : '0;
            result_reg.brake_distance <= found_reg ? dist_reg : '0;
            result_reg.onset_found    <= found_reg;
        end
    end

endmodule

/* rtl/brake_onset_decel_distance_core.sv */
// ============================================================================
// brake_onset_decel_distance_core: brake onset, mean decel and distance
// Tracks the pedal force run per sample and reports one result per record.
// ============================================================================
//  channel   direction  handshake                payload
//  sample    in         sample_valid/stall       sample_t (accel, velocity, force, last)
//  result    out        result_valid/stall       result_t (status .. onset_found)
//  cfg       in         cfg_we                   cfg_index, cfg_data
//
//  A sample with last low is accepted without a stall. A last sample holds off
//  the next request while the shift-subtract divider works out the mean and
//  through the load state, which waits while the output register is still full.
//  Reset clears the record and sets the registers to their defaults.
//  A pending result does not stall samples; only the divider and its hand-off do.
module brake_onset_decel_distance_core
    import bodd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  sample_t           sample,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    bodd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_last  (sample.last),
        .sample_stall (sample_stall),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    bodd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* tb/sv/tb.sv */
// ============================================================================
// tb: self-checking regression for brake_onset_decel_distance_core
// Streams brake-test records through the sample channel, keeps its own
// streaming copy of the onset tracker to predict each record result, and
// compares every accepted result field by field under several idle mixes
// and register settings.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bodd_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 40;       // covers the divider and result hand-off after a last sample
    localparam int PHASES       = 8;
    localparam int RECORDS      = 1;

    typedef enum {F_ABOVE, F_BELOW, F_NOISE} force_kind_t;

    // Tracks the current record sample by sample and queues the report
    // that each last sample must produce.
    class onset_tracker_t;
        bit [15:0]          thr;
        bit [15:0]          step;
        int                 idx;
        int                 run;
        bit                 locked;
        longint             v_sum;
        longint             a_sum;
        int                 n_sum;
        logic signed [15:0] v_before;
        logic signed [15:0] v_prev;
        int                 last_above;
        bit                 seen_above;
        bit                 ovf;
        result_t            reports[$];
        int                 failures;
        int                 samples;
        int                 records;
        int                 n_onset;
        int                 n_near;
        int                 n_ovf;
        int                 n_none;

        function new();
            thr  = '0;
            step = STEP_TIME_RESET;
            clear();
        endfunction

        function void clear();
            idx        = 0;
            run        = 0;
            locked     = 1'b0;
            v_sum      = 0;
            a_sum      = 0;
            n_sum      = 0;
            v_before   = '0;
            v_prev     = '0;
            last_above = 0;
            seen_above = 1'b0;
            ovf        = 1'b0;
        endfunction

        function void set_regs(bit [15:0] t, bit [15:0] s);
            thr  = t;
            step = s;
        endfunction

        function int outstanding();
            return reports.size();
        endfunction

        function void note_fail(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void take_sample(sample_t s);
            longint  a;
            longint  v;
            bit      above;
            result_t r;
            a = $signed(s.accel);
            v = $signed(s.velocity);
            samples++;
            if (!ovf) begin
                if (idx >= MAX_SAMPLES) begin
                    ovf = 1'b1;
                end else begin
                    above = s.pedal_force > thr;
                    if (!locked) begin
                        if (above) begin
                            // a fresh run restarts the sums
                            if (run == 0) begin
                                v_before = (idx != 0) ? v_prev : '0;
                                v_sum    = 0;
                                a_sum    = 0;
                                n_sum    = 0;
                            end
                            if (run < RUN_LENGTH)
                                run++;
                            seen_above = 1'b1;
                            last_above = idx;
                            v_sum += v;
                            a_sum += a;
                            n_sum++;
                            if (run >= RUN_LENGTH)
                                locked = 1'b1;
                        end else begin
                            run = 0;
                        end
                    end else begin
                        v_sum += v;
                        a_sum += a;
                        n_sum++;
                    end
                    v_prev = s.velocity;
                    idx++;
                end
            end
            if (!s.last)
                return;
            r = '0;
            r.status = ST_OK;
            if (ovf) begin
                r.status = ST_OVERFLOW;
                n_ovf++;
            end else if (locked) begin
                r.onset_found    = 1'b1;
                r.start_velocity = v_before;
                if (n_sum != 0)
                    r.mean_decel = DATA_W'(a_sum / longint'(n_sum));
                r.brake_distance = DIST_W'(longint'(step) * v_sum);
                n_onset++;
            end else if (seen_above && last_above + RUN_LENGTH > idx) begin
                r.status = ST_NEAR_END;
                n_near++;
            end else begin
                r.start_velocity = v_prev;
                n_none++;
            end
            records++;
            reports = {reports, r};
            clear();
        endfunction

        function void check_report(result_t got);
            result_t want;
            if (reports.size() == 0) begin
                note_fail($sformatf("unexpected result: status=%0d sv=%0d mean=%0d dist=%0d onset=%0d",
                                    got.status, got.start_velocity, got.mean_decel,
                                    got.brake_distance, got.onset_found));
                return;
            end
            want = reports.pop_front();
            if (got.status !== want.status || got.start_velocity !== want.start_velocity ||
                got.mean_decel !== want.mean_decel ||
                got.brake_distance !== want.brake_distance ||
                got.onset_found !== want.onset_found)
                note_fail($sformatf({"mismatch: expected status=%0d sv=%0d mean=%0d dist=%0d ",
                                     "onset=%0d, got status=%0d sv=%0d mean=%0d dist=%0d onset=%0d"},
                                    want.status, want.start_velocity, want.mean_decel,
                                    want.brake_distance, want.onset_found,
                                    got.status, got.start_velocity, got.mean_decel,
                                    got.brake_distance, got.onset_found));
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_we       = 1'b0;
    logic              cfg_index    = CFG_FORCE_THRESHOLD;
    logic [DATA_W-1:0] cfg_data     = '0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    sample_t           sample_req   = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result_rsp;

    onset_tracker_t board = new();
    int             gap_pct   = 0;
    int             stall_pct = 0;
    int             hold_ask  = 0;
    int             hold_left = 0;
    int             cycles    = 0;

    brake_onset_decel_distance_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, board.outstanding());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_report(result_rsp);
    end

    // Receiver: a requested hold-off wins over random stalls.
    always @(negedge clk)
    begin
        if (hold_ask != 0)
        begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic signed [15:0] rand16();
        case ($urandom_range(9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] force_of(force_kind_t k);
        case (k)
            F_ABOVE: return (board.thr == 16'hFFFF) ? 16'hFFFF :
                            16'($urandom_range(65535, int'(board.thr) + 1));
            F_BELOW: return 16'($urandom_range(int'(board.thr), 0));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sample_t mk(int acc, int vel, int frc, bit fin);
        sample_t s;
        s.accel       = 16'(acc);
        s.velocity    = 16'(vel);
        s.pedal_force = 16'(frc);
        s.last        = fin;
        return s;
    endfunction

    function automatic void add_seg(ref sample_t q[$], input int n, input force_kind_t k);
        for (int i = 0; i < n; i++)
            q = {q, mk(rand16(), rand16(), force_of(k), 1'b0)};
    endfunction

    task automatic set_idle(input int mode);
        case (mode)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 46; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 46; end
            default: begin gap_pct = 33; stall_pct = 33; end
        endcase
    endtask

    task automatic send(input sample_t s);
        while ($urandom_range(99) < gap_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_req   <= s;
        do @(posedge clk); while (sample_stall);
        board.take_sample(s);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_regs(input bit [15:0] thr, input bit [15:0] step);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FORCE_THRESHOLD;
        cfg_data  <= thr;
        @(negedge clk);
        cfg_index <= CFG_STEP_TIME;
        cfg_data  <= step;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_regs(thr, step);
    endtask

    task automatic send_queue(ref sample_t rec[$]);
        if (rec.size() == 0)
            add_seg(rec, 1, F_NOISE);
        rec[rec.size()-1].last = 1'b1;
        foreach (rec[i])
            send(rec[i]);
    endtask

    task automatic random_record();
        sample_t rec[$];
        int      pick;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            // confirmed onset, sometimes right at the first sample
            if ($urandom_range(3) != 0)
                add_seg(rec, $urandom_range(40, 1), F_NOISE);
            add_seg(rec, $urandom_range(RUN_LENGTH + 30, RUN_LENGTH), F_ABOVE);
            add_seg(rec, $urandom_range(40), F_NOISE);
        end
        else if (pick < 55)
        begin
            // run broken just short of the length, then a full one
            add_seg(rec, $urandom_range(RUN_LENGTH - 1, RUN_LENGTH - 50), F_ABOVE);
            add_seg(rec, $urandom_range(3, 1), F_BELOW);
            add_seg(rec, $urandom_range(RUN_LENGTH + 10, RUN_LENGTH), F_ABOVE);
            add_seg(rec, $urandom_range(10), F_NOISE);
        end
        else if (pick < 70)
        begin
            // run cut off by the end of the record
            add_seg(rec, $urandom_range(20), F_NOISE);
            add_seg(rec, $urandom_range(RUN_LENGTH - 1, 1), F_ABOVE);
            add_seg(rec, $urandom_range(RUN_LENGTH - 2), F_BELOW);
        end
        else if (pick < 80)
        begin
            // short run far enough from the end to be ignored
            add_seg(rec, $urandom_range(20, 1), F_ABOVE);
            add_seg(rec, $urandom_range(RUN_LENGTH + 5, RUN_LENGTH - 1), F_BELOW);
        end
        else
        begin
            add_seg(rec, $urandom_range(12, 1), F_NOISE);
        end
        send_queue(rec);
    endtask

    initial
    begin
        sample_t     rec[$];
        bit [15:0]   thr_set[PHASES];
        bit [15:0]   step_set[PHASES];
        bit [15:0]   thr;
        bit [15:0]   step;

        thr_set  = '{16'd30000, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd65534, 16'd32768, 16'd0};
        step_set = '{16'd655, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd65535, 16'd0, 16'd0};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset registers first, then the extremes
        send(mk(32767, -32768, 0, 1'b1));
        send(mk(-32768, 32767, 65535, 1'b1));
        send(mk(0, 0, 1, 1'b0));
        send(mk(-1, -1, 0, 1'b0));
        send(mk(1, 1, 0, 1'b1));
        wait_drained();
        set_regs(16'hFFFF, 16'hFFFF);
        send(mk(12, -7, 65535, 1'b1));
        send(mk(0, 0, 65535, 1'b0));
        send(mk(1, 1, 32768, 1'b0));
        send(mk(-1, -1, 0, 1'b1));
        wait_drained();
        set_regs(16'd0, 16'd0);
        send(mk(100, 200, 1, 1'b0));
        send(mk(-100, -200, 0, 1'b1));
        send(mk(5, 5, 0, 1'b1));
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            thr  = (p == 4 || p == 7) ? 16'($urandom) : thr_set[p];
            step = (p == 4 || p == 7) ? 16'($urandom) : step_set[p];
            set_regs(thr, step);
            set_idle(p % 4);
            if (p == 2)
            begin
                // hold the result side off while short records keep coming
                hold_ask = 600;
                for (int r = 0; r < 12; r++)
                begin
                    rec.delete();
                    add_seg(rec, $urandom_range(4, 1), F_NOISE);
                    send_queue(rec);
                end
            end
            for (int r = 0; r < RECORDS; r++)
                random_record();
            wait_drained();
        end

        if (board.outstanding() != 0)
            board.note_fail($sformatf("%0d results never arrived", board.outstanding()));
        $display("Sent %0d samples in %0d records: %0d with onset, %0d near end,",
                 board.samples, board.records, board.n_onset, board.n_near);
        $display("%0d overflow, %0d without onset; %0d register settings, %0d mismatches",
                 board.n_ovf, board.n_none, PHASES + 3, board.failures);
        if (board.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
